### rtl/core/lhik_pkg.sv
`timescale 1ns / 1ps
package lhik_pkg;

   localparam int JOINTS = 2;
   localparam int HIP = 0;
   localparam int KNEE = 1;
   localparam int DIVISOR = 46;
   localparam int HALF_PI_Q12 = 6434;
   localparam int CODE_W = 13;

   localparam logic [2:0] CSR_POSITION_GAIN = 3'd0;
   localparam logic [2:0] CSR_RATE_GAIN = 3'd1;
   localparam logic [2:0] CSR_HIP_LIMIT = 3'd2;
   localparam logic [2:0] CSR_KNEE_LIMIT = 3'd3;
   localparam logic [2:0] CSR_CONTROL_RATE = 3'd4;

   typedef struct packed {
      logic rate_en;
      logic sat_en;
      logic prod_en;
      logic sum_en;
   } lane_ctl_type;

   function automatic longint cos_q30(input logic [63:0] a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint sum;
      x = a << 18;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      term = ((term * x2) >> 30) / 64'd2;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      sum = sum - longint'(term);
      return sum;
   endfunction

   function automatic logic [CODE_W-1:0] acos_code(input longint r);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'd0;
      hi = 64'(HALF_PI_Q12);
      for (int k = 0; k < 16; k++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (cos_q30(mid) <= r) begin
               hi = mid;
            end else begin
               lo = mid + 64'd1;
            end
         end
      end
      return lo[CODE_W-1:0];
   endfunction

endpackage

### rtl/core/lhik_req_if.sv
`timescale 1ns / 1ps
interface lhik_req_if;
   logic valid;
   logic ready;
   logic [15:0] hip_height;
   logic signed [15:0] hip_angle_meas;
   logic signed [15:0] knee_angle_meas;
   logic signed [23:0] hip_rate_meas;
   logic signed [23:0] knee_rate_meas;
   logic restart;

   modport source (output valid, hip_height, hip_angle_meas, knee_angle_meas,
      hip_rate_meas, knee_rate_meas, restart, input ready);
   modport sink (input valid, hip_height, hip_angle_meas, knee_angle_meas,
      hip_rate_meas, knee_rate_meas, restart, output ready);
endinterface

### rtl/core/lhik_rsp_if.sv
`timescale 1ns / 1ps
interface lhik_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] hip_torque;
   logic signed [15:0] knee_torque;
   logic signed [15:0] hip_angle_target;
   logic signed [15:0] knee_angle_target;
   logic signed [23:0] hip_rate_target;
   logic signed [23:0] knee_rate_target;

   modport source (output valid, hip_torque, knee_torque, hip_angle_target,
      knee_angle_target, hip_rate_target, knee_rate_target, input ready);
   modport sink (input valid, hip_torque, knee_torque, hip_angle_target,
      knee_angle_target, hip_rate_target, knee_rate_target, output ready);
endinterface

### rtl/core/leg_height_ik_pd_torque_unit.sv
`timescale 1ns / 1ps
// Two-joint leg PD torque unit driven by a desired hip height.
// req carries one item per control sample: hip height and the measured
// hip and knee angles and rates, plus a restart flag. rsp returns one item
// per request: clamped torques, angle targets and rate targets.
// Gains, torque limits and the control rate are written on the csr port;
// the user must write them only while the unit is idle, which the unit
// does not enforce. Writes to unused indexes are dropped. One item is in
// work at a time. From accept to rsp valid, the height is scaled by 50
// times the table depth, divided by 23 (half of 46) with a reciprocal
// multiply, interpolated from the acos table, handed to the two joint
// lanes, run through four lane stages and loaded into the result register.
// The next item is taken in the cycle after the result is loaded.
// The result register holds its item while rsp stalls; a new request is
// accepted meanwhile, but its result waits until the held item is taken.
// Synchronous reset restores the register defaults, clears the previous
// targets and marks the next item as the first sample (zero target rates).
module leg_height_ik_pd_torque_unit #(
   parameter int ACOS_TABLE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   lhik_req_if.sink req,
   lhik_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_IK = 3'd1;
   localparam logic [2:0] S_RATE = 3'd2;
   localparam logic [2:0] S_SAT = 3'd3;
   localparam logic [2:0] S_PROD = 3'd4;
   localparam logic [2:0] S_SUM = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;
   localparam int J = lhik_pkg::JOINTS;

   logic [2:0] state_ff, state_in;
   logic [15:0] kp_ff, kd_ff, crate_ff;
   logic [14:0] hip_lim_ff, knee_lim_ff;
   logic signed [15:0] prev_ff [J];
   logic first_ff;
   logic fresh_ff;
   logic signed [15:0] ameas_ff [J];
   logic signed [23:0] rmeas_ff [J];
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] torque_ff [J];
   logic signed [15:0] tgt_ff [J];
   logic signed [23:0] rate_ff [J];

   logic accept;
   logic load_out;
   logic ik_done;
   logic [lhik_pkg::CODE_W-1:0] hip_code;
   logic signed [15:0] tgt [J];
   logic [14:0] lim [J];
   logic signed [15:0] lane_torque [J];
   logic signed [23:0] lane_rate [J];
   lhik_pkg::lane_ctl_type ctl;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   lhik_ik #(.ACOS_TABLE_DEPTH(ACOS_TABLE_DEPTH)) u_ik (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .hip_height(req.hip_height),
      .done(ik_done),
      .hip_code(hip_code)
   );

   assign tgt[lhik_pkg::HIP] = $signed(16'(hip_code));
   assign tgt[lhik_pkg::KNEE] = $signed(16'd0 - {2'b00, hip_code, 1'b0});
   assign lim[lhik_pkg::HIP] = hip_lim_ff;
   assign lim[lhik_pkg::KNEE] = knee_lim_ff;

   always_comb begin
      ctl.rate_en = (state_ff == S_RATE);
      ctl.sat_en = (state_ff == S_SAT);
      ctl.prod_en = (state_ff == S_PROD);
      ctl.sum_en = (state_ff == S_SUM);
   end

   for (genvar j = 0; j < J; j++) begin : g_lane
      lhik_lane u_lane (
         .clock(clock),
         .ctl(ctl),
         .target(tgt[j]),
         .prev_target(prev_ff[j]),
         .angle_meas(ameas_ff[j]),
         .rate_meas(rmeas_ff[j]),
         .torque_limit(lim[j]),
         .position_gain(kp_ff),
         .rate_gain(kd_ff),
         .control_rate_hz(crate_ff),
         .fresh(fresh_ff),
         .torque(lane_torque[j]),
         .rate_target(lane_rate[j])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_IK;
            end
         end
         S_IK: begin
            if (ik_done) begin
               state_in = S_RATE;
            end
         end
         S_RATE: state_in = S_SAT;
         S_SAT: state_in = S_PROD;
         S_PROD: state_in = S_SUM;
         S_SUM: state_in = S_OUT;
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff <= 16'd0;
         kd_ff <= 16'd0;
         hip_lim_ff <= 15'd5120;
         knee_lim_ff <= 15'd5120;
         crate_ff <= 16'd1000;
         first_ff <= 1'b1;
         prev_ff[lhik_pkg::HIP] <= '0;
         prev_ff[lhik_pkg::KNEE] <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               lhik_pkg::CSR_POSITION_GAIN: kp_ff <= csr_wdata;
               lhik_pkg::CSR_RATE_GAIN: kd_ff <= csr_wdata;
               lhik_pkg::CSR_HIP_LIMIT: hip_lim_ff <= csr_wdata[14:0];
               lhik_pkg::CSR_KNEE_LIMIT: knee_lim_ff <= csr_wdata[14:0];
               lhik_pkg::CSR_CONTROL_RATE: crate_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (load_out) begin
            first_ff <= 1'b0;
            prev_ff <= tgt;
         end
      end
      if (accept) begin
         fresh_ff <= first_ff || req.restart;
         ameas_ff[lhik_pkg::HIP] <= req.hip_angle_meas;
         ameas_ff[lhik_pkg::KNEE] <= req.knee_angle_meas;
         rmeas_ff[lhik_pkg::HIP] <= req.hip_rate_meas;
         rmeas_ff[lhik_pkg::KNEE] <= req.knee_rate_meas;
      end
      if (load_out) begin
         torque_ff <= lane_torque;
         tgt_ff <= tgt;
         rate_ff <= lane_rate;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.hip_torque = torque_ff[lhik_pkg::HIP];
   assign rsp.knee_torque = torque_ff[lhik_pkg::KNEE];
   assign rsp.hip_angle_target = tgt_ff[lhik_pkg::HIP];
   assign rsp.knee_angle_target = tgt_ff[lhik_pkg::KNEE];
   assign rsp.hip_rate_target = rate_ff[lhik_pkg::HIP];
   assign rsp.knee_rate_target = rate_ff[lhik_pkg::KNEE];
endmodule

### rtl/core/lhik_ik.sv
`timescale 1ns / 1ps
module lhik_ik #(
   parameter int ACOS_TABLE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [15:0] hip_height,
   output logic done,
   output logic [lhik_pkg::CODE_W-1:0] hip_code
);
   localparam int HALF_DIV = lhik_pkg::DIVISOR / 2;
   localparam int HALF_MULT = ACOS_TABLE_DEPTH * 50;
   localparam int X_W = $clog2(64'd65535 * 64'(HALF_MULT) + 64'd1);
   localparam int SHIFT = X_W + $clog2(HALF_DIV);
   localparam int M_W = X_W + 1;
   localparam int P_W = X_W + M_W;
   localparam int Q_W = P_W - SHIFT;
   localparam longint MAGIC =
      ((longint'(1) << SHIFT) + longint'(HALF_DIV - 1)) / longint'(HALF_DIV);
   localparam int IDX_W = $clog2(ACOS_TABLE_DEPTH + 1);
   localparam int CW = lhik_pkg::CODE_W;

   logic [CW-1:0] rom [ACOS_TABLE_DEPTH+1];

   for (genvar i = 0; i <= ACOS_TABLE_DEPTH; i++) begin : g_rom
      localparam longint R = (longint'(i) << 30) / ACOS_TABLE_DEPTH;
      localparam logic [CW-1:0] V = lhik_pkg::acos_code(R);
      assign rom[i] = V;
   end

   logic [X_W-1:0] num_ff, num_in;
   logic [Q_W-1:0] quo_ff, quo_in;
   logic mul_ff, mul_in;
   logic interp_ff, interp_in;
   logic done_ff, done_in;
   logic [CW-1:0] hip_ff, hip_in;

   logic [P_W-1:0] recip;
   logic [Q_W-17:0] idx_full;
   logic [IDX_W-1:0] idx;
   logic [15:0] frac;
   logic [CW-1:0] t0, t1, d;
   logic [CW+16:0] prod;

   always_comb begin
      num_in = X_W'(hip_height) * X_W'(HALF_MULT);
      recip = P_W'(num_ff) * P_W'(MAGIC);
      quo_in = recip[P_W-1:SHIFT];
      mul_in = start;
      interp_in = mul_ff;
      done_in = interp_ff;
   end

   always_comb begin
      idx_full = quo_ff[Q_W-1:16];
      idx = idx_full[IDX_W-1:0];
      frac = quo_ff[15:0];
      t0 = rom[idx];
      t1 = rom[idx + IDX_W'(1)];
      d = (t0 > t1) ? (t0 - t1) : '0;
      prod = (CW+17)'(d) * (CW+17)'(frac) + (CW+17)'(32768);
      if (idx_full >= (Q_W-16)'(ACOS_TABLE_DEPTH)) begin
         hip_in = '0;
      end else begin
         hip_in = t0 - prod[CW+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
         interp_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff <= mul_in;
         interp_ff <= interp_in;
         done_ff <= done_in;
      end
      if (start) begin
         num_ff <= num_in;
      end
      if (mul_ff) begin
         quo_ff <= quo_in;
      end
      if (interp_ff) begin
         hip_ff <= hip_in;
      end
   end

   assign done = done_ff;
   assign hip_code = hip_ff;
endmodule

### rtl/core/lhik_lane.sv
`timescale 1ns / 1ps
module lhik_lane (
   input  logic clock,
   input  lhik_pkg::lane_ctl_type ctl,
   input  logic signed [15:0] target,
   input  logic signed [15:0] prev_target,
   input  logic signed [15:0] angle_meas,
   input  logic signed [23:0] rate_meas,
   input  logic [14:0] torque_limit,
   input  logic [15:0] position_gain,
   input  logic [15:0] rate_gain,
   input  logic [15:0] control_rate_hz,
   input  logic fresh,
   output logic signed [15:0] torque,
   output logic signed [23:0] rate_target
);
   logic signed [33:0] rprod_ff;
   logic signed [16:0] aerr_ff;
   logic signed [23:0] rate_ff, rate_in;
   logic signed [24:0] rerr_ff;
   logic signed [33:0] pprod_ff;
   logic signed [41:0] dprod_ff;
   logic signed [15:0] torque_ff, torque_in;

   logic signed [16:0] diff;
   logic signed [16:0] aerr;
   logic signed [24:0] rerr;
   logic signed [42:0] acc;
   logic signed [30:0] shifted;
   logic signed [30:0] lim;

   always_comb begin
      diff = {target[15], target} - {prev_target[15], prev_target};
      aerr = {target[15], target} - {angle_meas[15], angle_meas};
      if (fresh) begin
         rate_in = '0;
      end else if (rprod_ff > 34'sd8388607) begin
         rate_in = 24'sh7FFFFF;
      end else if (rprod_ff < -34'sd8388608) begin
         rate_in = 24'sh800000;
      end else begin
         rate_in = rprod_ff[23:0];
      end
      rerr = {rate_in[23], rate_in} - {rate_meas[23], rate_meas};
      acc = 43'(pprod_ff) + 43'(dprod_ff) + 43'sd2048;
      shifted = acc[42:12];
      lim = $signed({16'd0, torque_limit});
      if (shifted > lim) begin
         torque_in = lim[15:0];
      end else if (shifted < -lim) begin
         torque_in = 16'(-lim);
      end else begin
         torque_in = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rate_en) begin
         rprod_ff <= diff * $signed({1'b0, control_rate_hz});
         aerr_ff <= aerr;
      end
      if (ctl.sat_en) begin
         rate_ff <= rate_in;
         rerr_ff <= rerr;
      end
      if (ctl.prod_en) begin
         pprod_ff <= aerr_ff * $signed({1'b0, position_gain});
         dprod_ff <= rerr_ff * $signed({1'b0, rate_gain});
      end
      if (ctl.sum_en) begin
         torque_ff <= torque_in;
      end
   end

   assign torque = torque_ff;
   assign rate_target = rate_ff;
endmodule
